### src/bounded_random_bigint_gen_defines.svh
// Assertion macros shared by the bounded random number generator sources.
`ifndef BOUNDED_RANDOM_BIGINT_GEN_DEFINES_SVH
`define BOUNDED_RANDOM_BIGINT_GEN_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BRBG_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BRBG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRBG_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BRBG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/brbg_pkg.sv
// Shared types, constants and helper functions of the bounded random number generator.
package brbg_pkg;

	localparam int WORD_W        = 64;
	localparam int NUM_WORDS     = 4;
	localparam int WIDX_W        = $clog2(NUM_WORDS);
	localparam int POS_W         = 2;
	localparam int CNT_W         = 3;
	localparam int ADDR_W        = 6;
	localparam int BYTE_SH       = 3;
	localparam int MAX_LIMBS_DEF = 4;

	localparam int ROT_OUT   = 23;
	localparam int ROT_STATE = 45;
	localparam int SHIFT_B   = 17;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t SEED_RESET [NUM_WORDS] = '{64'd1, 64'd2, 64'd3, 64'd4};
	localparam word_t BOUND_RESET [NUM_WORDS] = '{64'd1, 64'd0, 64'd0, 64'd0};

	typedef enum logic [2:0] {
		REG_SEED_0,
		REG_SEED_1,
		REG_SEED_2,
		REG_SEED_3,
		REG_BOUND_0,
		REG_BOUND_1,
		REG_BOUND_2,
		REG_BOUND_3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW_TOP,
		ST_DRAW_LOW,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic draw_top;
		logic draw_low;
		logic emit_next;
	} cmd_t;

	typedef struct packed {
		logic bound_nz;
		logic top_fit;
		logic top_lt;
		logic top_single;
		logic low_last;
		logic low_lt;
		logic emit_last;
	} sts_t;

	typedef struct packed {
		logic              en;
		logic [WIDX_W-1:0] idx;
		word_t             data;
	} seed_load_t;

	function automatic word_t rotl(word_t v, int unsigned amt);
		return (v << amt) | (v >> (WORD_W - amt));
	endfunction

	// Fill every bit below the leading one.
	function automatic word_t smear(word_t v);
		word_t r;
		r = v;
		for (int i = 0; i < $clog2(WORD_W); i++) begin
			r = r | (r >> (1 << i));
		end
		return r;
	endfunction

endpackage

### src/brbg_ctrl.sv
// Sequencer of the bounded random number generator: draw, retry and emit control.
`include "bounded_random_bigint_gen_defines.svh"

module brbg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              draw_valid,
	input  logic              draw_request,
	output logic              draw_stall,
	output logic              limb_valid,
	input  logic              limb_stall,
	output brbg_pkg::cmd_t    cmd,
	input  brbg_pkg::sts_t    sts
);

	brbg_pkg::state_t state_q;
	brbg_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brbg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		draw_stall = 1'b1;
		limb_valid = 1'b0;
		case (state_q)
			brbg_pkg::ST_IDLE: begin
				draw_stall = 1'b0;
				if (draw_valid && draw_request && sts.bound_nz) begin
					cmd.start = 1'b1;
					state_d   = brbg_pkg::ST_DRAW_TOP;
				end
			end
			brbg_pkg::ST_DRAW_TOP: begin
				cmd.draw_top = 1'b1;
				if (sts.top_fit) begin
					if (!sts.top_single) begin
						state_d = brbg_pkg::ST_DRAW_LOW;
					end else if (sts.top_lt) begin
						state_d = brbg_pkg::ST_EMIT;
					end
				end
			end
			brbg_pkg::ST_DRAW_LOW: begin
				cmd.draw_low = 1'b1;
				if (sts.low_last) begin
					state_d = sts.low_lt ? brbg_pkg::ST_EMIT : brbg_pkg::ST_DRAW_TOP;
				end
			end
			brbg_pkg::ST_EMIT: begin
				limb_valid = 1'b1;
				if (!limb_stall) begin
					cmd.emit_next = 1'b1;
					if (sts.emit_last) begin
						state_d = brbg_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = brbg_pkg::ST_IDLE;
			end
		endcase
	end

	`BRBG_ASSERT_NEXT(a_emit_done, state_q == brbg_pkg::ST_EMIT && !limb_stall && sts.emit_last, state_q == brbg_pkg::ST_IDLE, "emit did not return to idle after last limb")
	`BRBG_ASSERT_IMPLY(a_emit_entry, $rose(state_q == brbg_pkg::ST_EMIT), $past(state_q) == brbg_pkg::ST_DRAW_TOP || $past(state_q) == brbg_pkg::ST_DRAW_LOW, "emit entered without a finished draw")

endmodule

### src/brbg_dp.sv
// Datapath: xoshiro256++ generator, candidate limbs, bound compare and result fields.
`include "bounded_random_bigint_gen_defines.svh"

module brbg_dp #(
	parameter int MAX_LIMBS = brbg_pkg::MAX_LIMBS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  brbg_pkg::seed_load_t         seed_load,
	input  brbg_pkg::word_t              bound [brbg_pkg::NUM_WORDS],
	input  brbg_pkg::cmd_t               cmd,
	output brbg_pkg::sts_t               sts,
	output logic [brbg_pkg::WORD_W-1:0]  limb_value,
	output logic [brbg_pkg::POS_W-1:0]   limb_position,
	output logic [brbg_pkg::CNT_W-1:0]   used_limbs,
	output logic                         last_limb
);

	localparam int IDX_W = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;

	// Generator state and the sum g0 + g3, registered from the next state so that it matches g_q.
	brbg_pkg::word_t g_q   [brbg_pkg::NUM_WORDS];
	brbg_pkg::word_t g_n   [brbg_pkg::NUM_WORDS];
	brbg_pkg::word_t g_sel [brbg_pkg::NUM_WORDS];
	brbg_pkg::word_t sum_q;
	brbg_pkg::word_t word;
	brbg_pkg::word_t t_shift;
	brbg_pkg::word_t x2;
	brbg_pkg::word_t x3;

	logic [brbg_pkg::CNT_W-1:0] top_c;
	logic [brbg_pkg::CNT_W-1:0] top_q;
	logic [IDX_W-1:0]           top_idx_c;
	logic [IDX_W-1:0]           top_idx;
	brbg_pkg::word_t            hi_c;
	brbg_pkg::word_t            hi_q;
	brbg_pkg::word_t            mask_q;
	brbg_pkg::word_t            m;

	brbg_pkg::word_t  cand_q [MAX_LIMBS];
	logic             nz_q   [MAX_LIMBS];
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] cnt_m1;
	logic             lt_q;
	logic             gt_q;
	brbg_pkg::word_t  b_low;
	logic             top_fit;
	logic             top_lt;
	logic             low_lt;
	logic             low_gt;
	logic             step;
	logic [brbg_pkg::CNT_W-1:0] used_c;

	assign step = cmd.draw_top | cmd.draw_low;

	always_comb begin
		t_shift = g_q[1] << brbg_pkg::SHIFT_B;
		x2      = g_q[2] ^ g_q[0];
		x3      = g_q[3] ^ g_q[1];
		g_n[1]  = g_q[1] ^ x2;
		g_n[0]  = g_q[0] ^ x3;
		g_n[2]  = x2 ^ t_shift;
		g_n[3]  = brbg_pkg::rotl(x3, brbg_pkg::ROT_STATE);
	end

	always_comb begin
		g_sel = g_q;
		if (seed_load.en) begin
			g_sel[seed_load.idx] = seed_load.data;
		end else if (step) begin
			g_sel = g_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q   <= brbg_pkg::SEED_RESET;
			sum_q <= brbg_pkg::SEED_RESET[0] + brbg_pkg::SEED_RESET[3];
		end else begin
			g_q   <= g_sel;
			sum_q <= g_sel[0] + g_sel[3];
		end
	end

	assign word = brbg_pkg::rotl(sum_q, brbg_pkg::ROT_OUT) + g_q[0];

	// Limbs in use: highest nonzero bound limb plus one.
	always_comb begin
		top_c = '0;
		for (int i = 0; i < MAX_LIMBS; i++) begin
			if (bound[i] != '0) begin
				top_c = brbg_pkg::CNT_W'(i + 1);
			end
		end
	end

	assign top_idx_c = IDX_W'(top_c - brbg_pkg::CNT_W'(1));
	assign top_idx   = IDX_W'(top_q - brbg_pkg::CNT_W'(1));
	assign hi_c      = bound[top_idx_c];

	assign m       = word & mask_q;
	assign top_fit = (m <= hi_q);
	assign top_lt  = (m < hi_q);

	assign cnt_m1 = cnt_q - IDX_W'(1);
	assign b_low  = bound[cnt_m1];
	assign low_lt = lt_q | (~gt_q & (word < b_low));
	assign low_gt = gt_q | (~lt_q & (word > b_low));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			cnt_q <= '0;
			lt_q  <= 1'b0;
			gt_q  <= 1'b0;
			for (int i = 0; i < MAX_LIMBS; i++) begin
				nz_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.start) begin
				top_q <= top_c;
			end
			if (cmd.draw_top && top_fit) begin
				nz_q[top_idx] <= (m != '0);
				cnt_q         <= top_idx;
				lt_q          <= top_lt;
				gt_q          <= 1'b0;
			end
			if (cmd.draw_low) begin
				nz_q[cnt_m1] <= (word != '0);
				cnt_q        <= cnt_m1;
				lt_q         <= low_lt;
				gt_q         <= low_gt;
			end
			if (cmd.emit_next) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hi_q   <= hi_c;
			mask_q <= brbg_pkg::smear(hi_c);
		end
		if (cmd.draw_top && top_fit) begin
			cand_q[top_idx] <= m;
		end
		if (cmd.draw_low) begin
			cand_q[cnt_m1] <= word;
		end
	end

	always_comb begin
		used_c = '0;
		for (int i = 0; i < MAX_LIMBS; i++) begin
			if (nz_q[i] && (brbg_pkg::CNT_W'(i) < top_q)) begin
				used_c = brbg_pkg::CNT_W'(i + 1);
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.bound_nz   = (top_c != '0);
		sts.top_fit    = top_fit;
		sts.top_lt     = top_lt;
		sts.top_single = (top_q == brbg_pkg::CNT_W'(1));
		sts.low_last   = (cnt_q == IDX_W'(1));
		sts.low_lt     = low_lt;
		sts.emit_last  = (cnt_q == top_idx);
	end

	assign limb_value    = cand_q[cnt_q];
	assign limb_position = brbg_pkg::POS_W'(cnt_q);
	assign used_limbs    = used_c;
	assign last_limb     = sts.emit_last;

	`BRBG_ASSERT_NEXT(a_top_limb_fits, cmd.draw_top && top_fit, cand_q[top_idx] <= hi_q, "stored top limb exceeds bound top limb")
	`BRBG_ASSERT_IMPLY(a_low_index_nonzero, cmd.draw_low, cnt_q != '0, "low limb draw with limb index at zero")

endmodule

### src/bounded_random_bigint_gen.sv
// Top level of the bounded random number generator: register file and unit wiring.
//
//  channel   handshake              payload
//  -------   ---------------------  ----------------------------------------------
//  draw      draw_valid/draw_stall  draw_request
//  limb      limb_valid/limb_stall  limb_value, limb_position, used_limbs, last_limb
//  config    APB psel/penable       paddr, pwdata, prdata (64-bit registers, 8*i)
//
// A request is accepted in the idle state, then drawing starts: each attempt
// takes one word per limb in use, the top limb is redrawn until it does not exceed the bound's
// top limb, and a whole attempt is redone when the candidate is not below the bound.
// Then one beat per limb in use goes out, low limb first. The single generator word per cycle
// sets the pace of drawing, which limb_stall does not hold; limb_stall can hold each beat.
// Reset clears the generator to seeds 1, 2, 3, 4 and the bound to 1; no clearing pass.
// A stalled limb beat holds its fields; draw_stall stays high until the last beat leaves.
// A request with draw_request low or an all-zero bound is taken and dropped.

module bounded_random_bigint_gen #(
	parameter int MAX_LIMBS = brbg_pkg::MAX_LIMBS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [brbg_pkg::ADDR_W-1:0]   paddr,
	input  logic [brbg_pkg::WORD_W-1:0]   pwdata,
	output logic [brbg_pkg::WORD_W-1:0]   prdata,
	output logic                          pready,
	// request channel
	input  logic                          draw_valid,
	output logic                          draw_stall,
	input  logic                          draw_request,
	// result channel
	output logic                          limb_valid,
	input  logic                          limb_stall,
	output logic [brbg_pkg::WORD_W-1:0]   limb_value,
	output logic [brbg_pkg::POS_W-1:0]    limb_position,
	output logic [brbg_pkg::CNT_W-1:0]    used_limbs,
	output logic                          last_limb
);

	brbg_pkg::word_t      seed_q  [brbg_pkg::NUM_WORDS];
	brbg_pkg::word_t      bound_q [brbg_pkg::NUM_WORDS];
	brbg_pkg::reg_idx_t   reg_sel;
	brbg_pkg::seed_load_t seed_load;
	brbg_pkg::cmd_t       cmd;
	brbg_pkg::sts_t       sts;
	logic                 wr_en;

	// The port never waits.
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = brbg_pkg::reg_idx_t'(paddr[brbg_pkg::ADDR_W-1:brbg_pkg::BYTE_SH]);

	// Seed writes also load the matching generator word.
	always_comb begin
		seed_load      = '0;
		seed_load.data = pwdata;
		seed_load.idx  = paddr[brbg_pkg::BYTE_SH +: brbg_pkg::WIDX_W];
		case (reg_sel)
			brbg_pkg::REG_SEED_0,
			brbg_pkg::REG_SEED_1,
			brbg_pkg::REG_SEED_2,
			brbg_pkg::REG_SEED_3: begin
				seed_load.en = wr_en;
			end
			default: begin
				seed_load.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= brbg_pkg::SEED_RESET;
			bound_q <= brbg_pkg::BOUND_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				brbg_pkg::REG_SEED_0:  seed_q[0]  <= pwdata;
				brbg_pkg::REG_SEED_1:  seed_q[1]  <= pwdata;
				brbg_pkg::REG_SEED_2:  seed_q[2]  <= pwdata;
				brbg_pkg::REG_SEED_3:  seed_q[3]  <= pwdata;
				brbg_pkg::REG_BOUND_0: bound_q[0] <= pwdata;
				brbg_pkg::REG_BOUND_1: bound_q[1] <= pwdata;
				brbg_pkg::REG_BOUND_2: bound_q[2] <= pwdata;
				brbg_pkg::REG_BOUND_3: bound_q[3] <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// Read back the last written value.
	always_comb begin
		case (reg_sel)
			brbg_pkg::REG_SEED_0:  prdata = seed_q[0];
			brbg_pkg::REG_SEED_1:  prdata = seed_q[1];
			brbg_pkg::REG_SEED_2:  prdata = seed_q[2];
			brbg_pkg::REG_SEED_3:  prdata = seed_q[3];
			brbg_pkg::REG_BOUND_0: prdata = bound_q[0];
			brbg_pkg::REG_BOUND_1: prdata = bound_q[1];
			brbg_pkg::REG_BOUND_2: prdata = bound_q[2];
			brbg_pkg::REG_BOUND_3: prdata = bound_q[3];
			default:               prdata = '0;
		endcase
	end

	brbg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.draw_valid   (draw_valid),
		.draw_request (draw_request),
		.draw_stall   (draw_stall),
		.limb_valid   (limb_valid),
		.limb_stall   (limb_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	brbg_dp #(
		.MAX_LIMBS (MAX_LIMBS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.seed_load     (seed_load),
		.bound         (bound_q),
		.cmd           (cmd),
		.sts           (sts),
		.limb_value    (limb_value),
		.limb_position (limb_position),
		.used_limbs    (used_limbs),
		.last_limb     (last_limb)
	);

endmodule
